### rtl/sstf_pkg.sv
// Shared types and constants for the shortest-seek-first disk scheduler.
package sstf_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int CYL_BITS    = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TOTAL_BITS  = 22;

	typedef struct packed {
		logic [15:0] cylinder;
		logic        last_request;
	} req_t;

	typedef struct packed {
		logic [15:0] served_cylinder;
		logic [15:0] seek_distance;
		logic [20:0] total_seek;
		logic        final_result;
		logic        overflow;
	} rsp_t;

endpackage

### rtl/sstf_disk_scheduler.sv
// Shortest-seek-time-first disk scheduler: request table, scan engine and result register.
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req   (cylinder, last_request)
//  rsp       out        rsp_valid/rsp_stall  rsp   (served_cylinder .. overflow)
//  cfg       in         cfg_valid/cfg_ready  cfg_data (start_position)
//
// Loading accepts one request per cycle; requests are taken only between runs.
// Each result takes one table read per entry through the single read port, then the
// registered read data, then a commit in ST_EMIT that waits for the result register.
// Loading resumes once every loaded request of the run has been served.
// The table needs no clearing; reset clears count, flags and the result register.
// A waiting result holds the engine only until the result register is free.
module sstf_disk_scheduler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  sstf_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sstf_pkg::rsp_t       rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);
	import sstf_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EMIT} state_t;

	state_t                state_q;
	logic [CYL_BITS-1:0]   table_mem [TABLE_DEPTH];
	logic [CYL_BITS-1:0]   rd_data_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic [15:0]           start_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      scan_idx_q;
	logic [CNT_W-1:0]      served_q;
	logic [TABLE_DEPTH-1:0] marks_q;
	logic [CYL_BITS-1:0]   head_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic                  dropped_q;
	logic                  found_q;
	logic [CYL_BITS-1:0]   best_q;
	logic [IDX_W-1:0]      pick_q;
	logic [CYL_BITS-1:0]   pick_cyl_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  req_xfer;
	logic                  full;
	logic                  issue;
	logic [CYL_BITS-1:0]   seek_delta;
	logic                  take;
	logic                  scan_done;
	logic                  out_free;
	logic                  commit;
	logic [TOTAL_BITS-1:0] total_next;
	logic                  is_final;

	assign req_stall = (state_q != ST_LOAD);
	assign req_xfer  = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read issue: one table entry per cycle during a scan
	assign issue = (state_q == ST_SCAN) && (scan_idx_q < count_q);

	// Compare stage on the returned entry
	assign seek_delta = (head_q >= rd_data_s1) ? (head_q - rd_data_s1)
	                                           : (rd_data_s1 - head_q);
	assign take = rd_valid_s1 && !marks_q[rd_idx_s1] && (!found_q || seek_delta < best_q);
	assign scan_done = rd_valid_s1 && (CNT_W'(rd_idx_s1) == count_q - CNT_W'(1));

	// Commit of a chosen request
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign commit     = (state_q == ST_EMIT) && out_free;
	assign total_next = total_q + TOTAL_BITS'(best_q);
	assign is_final   = (served_q + CNT_W'(1) == count_q);

	// Request table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req_xfer && !full) begin
			table_mem[count_q[IDX_W-1:0]] <= req.cylinder[CYL_BITS-1:0];
		end
		rd_data_s1 <= table_mem[scan_idx_q[IDX_W-1:0]];
		rd_idx_s1  <= scan_idx_q[IDX_W-1:0];
	end

	// Start position register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	// Sequencer: load, scan, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rd_valid_s1 <= 1'b0;
			count_q     <= '0;
			scan_idx_q  <= '0;
			served_q    <= '0;
			marks_q     <= '0;
			head_q      <= '0;
			total_q     <= '0;
			dropped_q   <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			pick_cyl_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rd_valid_s1 <= issue;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (req_xfer) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (req.last_request) begin
							state_q    <= ST_SCAN;
							marks_q    <= '0;
							head_q     <= start_q[CYL_BITS-1:0];
							total_q    <= '0;
							served_q   <= '0;
							scan_idx_q <= '0;
							found_q    <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (take) begin
						found_q    <= 1'b1;
						best_q     <= seek_delta;
						pick_q     <= rd_idx_s1;
						pick_cyl_q <= rd_data_s1;
					end
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						rsp_q.served_cylinder <= pick_cyl_q;
						rsp_q.seek_distance   <= best_q;
						rsp_q.total_seek      <= total_next[20:0];
						rsp_q.final_result    <= is_final;
						rsp_q.overflow        <= dropped_q;
						marks_q[pick_q]       <= 1'b1;
						head_q                <= pick_cyl_q;
						total_q               <= total_next;
						served_q              <= served_q + CNT_W'(1);
						scan_idx_q            <= '0;
						found_q               <= 1'b0;
						if (is_final) begin
							state_q   <= ST_LOAD;
							count_q   <= '0;
							dropped_q <= 1'b0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

### sim/sstf_disk_scheduler_tb.sv
// Self-checking testbench for the shortest-seek-time-first disk scheduler.
`timescale 1ns / 1ps

module sstf_disk_scheduler_tb;
	import sstf_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 100;

	// Cylinder choice for random batches
	typedef enum int {
		CYL_ANY,
		CYL_NEAR_HEAD,
		CYL_TIE_SET,
		CYL_EDGES
	} cyl_mode_e;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Scheduler state as the testbench sees it
	logic [15:0] head_start;
	logic [15:0] loaded_cyl [TABLE_DEPTH];
	int          loaded_count;
	bit          batch_dropped;
	rsp_t        service_order [$];

	int          error_count;
	int          items_sent;
	bit          sender_gaps;
	bit          receiver_stalls;
	int unsigned cycle_count = 0;

	sstf_disk_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Load one request; on the last mark, work out the whole service order
	task automatic predict_service(input req_t item);
		logic [TABLE_DEPTH-1:0] done_mask;
		logic [15:0]            head;
		logic [21:0]            total;
		logic [15:0]            best;
		logic [15:0]            delta;
		int                     pick;
		bit                     found;
		rsp_t                   result;
		if (loaded_count < TABLE_DEPTH) begin
			loaded_cyl[loaded_count] = item.cylinder;
			loaded_count++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (!item.last_request)
			return;
		done_mask = '0;
		head      = head_start;
		total     = '0;
		for (int served = 0; served < loaded_count; served++) begin
			found = 1'b0;
			best  = '0;
			pick  = 0;
			for (int i = 0; i < loaded_count; i++) begin
				if (done_mask[i])
					continue;
				delta = (head >= loaded_cyl[i]) ? head - loaded_cyl[i] : loaded_cyl[i] - head;
				// strict compare keeps the earliest loaded on a tie
				if (!found || delta < best) begin
					found = 1'b1;
					best  = delta;
					pick  = i;
				end
			end
			done_mask[pick]        = 1'b1;
			head                   = loaded_cyl[pick];
			total                  = total + 22'(best);
			result.served_cylinder = head;
			result.seek_distance   = best;
			result.total_seek      = total[20:0];
			result.final_result    = (served + 1 == loaded_count);
			result.overflow        = batch_dropped;
			service_order.push_back(result);
		end
		loaded_count  = 0;
		batch_dropped = 1'b0;
	endtask

	// Sender gap: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (!sender_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] pick_cylinder(input cyl_mode_e mode);
		logic [15:0] offset;
		case (mode)
			CYL_NEAR_HEAD: begin
				offset = 16'($urandom_range(0, 64));
				return head_start + offset - 16'd32;
			end
			CYL_TIE_SET: begin
				// equal distances either side of the head and repeated values
				case ($urandom_range(0, 3))
					0: return head_start;
					1: return head_start + 16'd8;
					2: return head_start - 16'd8;
					default: return head_start + 16'd16;
				endcase
			end
			CYL_EDGES: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'($urandom_range(0, 15));
					default: return 16'hFFFF - 16'($urandom_range(0, 15));
				endcase
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// One request transfer, after a random gap
	task automatic queue_request(input logic [15:0] cyl, input logic last);
		req_t item;
		int   gap;
		item.cylinder     = cyl;
		item.last_request = last;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		predict_service(item);
		items_sent++;
	endtask

	task automatic send_batch(input int count, input cyl_mode_e mode);
		for (int i = 1; i <= count; i++)
			queue_request(pick_cylinder(mode), i == count);
	endtask

	// Drain all results, then give the engine time to go idle
	task automatic wait_for_idle();
		req_valid <= 1'b0;
		while (service_order.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_start_position(input logic [15:0] pos);
		wait_for_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= pos;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		head_start  = pos;
	endtask

	function automatic int pick_batch_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 8);
		if (roll < 95)
			return $urandom_range(9, TABLE_DEPTH - 1);
		return TABLE_DEPTH;
	endfunction

	// Extremes, ties, duplicates and the reset start position
	task automatic test_directed_cases();
		queue_request(16'h0000, 1'b1);
		queue_request(16'hFFFF, 1'b0);
		queue_request(16'h5555, 1'b0);
		queue_request(16'hAAAA, 1'b0);
		queue_request(16'h0001, 1'b1);
		set_start_position(16'd100);
		queue_request(16'd110, 1'b0);
		queue_request(16'd90, 1'b0);
		queue_request(16'd105, 1'b1);
		queue_request(16'd90, 1'b0);
		queue_request(16'd110, 1'b1);
		queue_request(16'd7, 1'b0);
		queue_request(16'd7, 1'b0);
		queue_request(16'd7, 1'b1);
		set_start_position(16'hFFFF);
		queue_request(16'h0000, 1'b0);
		queue_request(16'hFFFF, 1'b0);
		queue_request(16'h8000, 1'b1);
	endtask

	// Full table, then batches whose tail is dropped; the last mark still ends each batch
	task automatic test_table_overflow();
		set_start_position(16'($urandom_range(0, 65535)));
		send_batch(TABLE_DEPTH, CYL_ANY);
		send_batch(TABLE_DEPTH + 1, CYL_NEAR_HEAD);
		set_start_position(16'h0000);
		send_batch(TABLE_DEPTH + 5, CYL_EDGES);
	endtask

	// No idling on either side, then idling on one side only
	task automatic test_back_to_back();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int i = 0; i < 4; i++)
			send_batch(pick_batch_size(), cyl_mode_e'($urandom_range(0, 3)));
		receiver_stalls = 1'b1;
		for (int i = 0; i < 3; i++)
			send_batch(pick_batch_size(), cyl_mode_e'($urandom_range(0, 3)));
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b0;
		for (int i = 0; i < 3; i++)
			send_batch(pick_batch_size(), cyl_mode_e'($urandom_range(0, 3)));
	endtask

	// Random batches under random idling, start position moved between runs
	task automatic test_random_batches();
		int target;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		target          = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 3))
					0: set_start_position(16'h0000);
					1: set_start_position(16'hFFFF);
					default: set_start_position(16'($urandom_range(0, 65535)));
				endcase
			end
			send_batch(pick_batch_size(), cyl_mode_e'($urandom_range(0, 3)));
		end
	endtask

	// Receiver stall pattern
	initial begin
		int run_left;
		run_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!receiver_stalls) begin
				rsp_stall <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				rsp_stall <= 1'($urandom_range(0, 1));
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
				                                       : $urandom_range(0, 3);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] expected,
	                           input logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
			error_count++;
		end
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (service_order.size() == 0) begin
				$display("%0t: unexpected result, served_cylinder %0d", $time,
				         rsp.served_cylinder);
				error_count++;
			end else begin
				want = service_order.pop_front();
				check_field("served_cylinder", 32'(want.served_cylinder),
				            32'(rsp.served_cylinder));
				check_field("seek_distance", 32'(want.seek_distance),
				            32'(rsp.seek_distance));
				check_field("total_seek", 32'(want.total_seek), 32'(rsp.total_seek));
				check_field("final_result", 32'(want.final_result),
				            32'(rsp.final_result));
				check_field("overflow", 32'(want.overflow), 32'(rsp.overflow));
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          <= 1'b0;
		req_valid       <= 1'b0;
		req             <= '0;
		cfg_valid       <= 1'b0;
		cfg_data        <= '0;
		head_start      = '0;
		loaded_count    = 0;
		batch_dropped   = 1'b0;
		error_count     = 0;
		items_sent      = 0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_overflow();
		test_back_to_back();
		test_random_batches();

		wait_for_idle();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sstf_disk_scheduler.f
rtl/sstf_pkg.sv
rtl/sstf_disk_scheduler.sv
sim/sstf_disk_scheduler_tb.sv
